// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

   // Default leaf count and the node address width that goes with it.
   localparam int LEAVES_DEFAULT = 1024;
   localparam int ADDR_W_DEFAULT = 11;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 60;

   // Value of a node that no update has lowered yet.
   localparam logic [VALUE_W-1:0] SENTINEL = 60'd1000000000000000007;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

// ===== rtl/rmq_min_unit.sv =====
// Shared compare and select: one wide compare serves both the update
// read-modify-write and the query accumulation.
module rmq_min_unit (
   input  logic [rmq_pkg::VALUE_W-1:0] a_value,
   input  logic [rmq_pkg::VALUE_W-1:0] b_value,
   output logic [rmq_pkg::VALUE_W-1:0] min_value
);

   assign min_value = (a_value < b_value) ? a_value : b_value;

endmodule

// ===== rtl/rmq_node_ram.sv =====
// Node store: one write port and one read port with registered read data.
module rmq_node_ram #(
   parameter int ADDR_W = rmq_pkg::ADDR_W_DEFAULT
) (
   input  logic                        clock,
   input  rmq_pkg::ram_ctl_type        ctl,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [rmq_pkg::VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [rmq_pkg::VALUE_W-1:0] rd_data
);

   logic [rmq_pkg::VALUE_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [rmq_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rmq_seq.sv =====
// Sequencer: clearing pass, bottom-up range walk for updates, leaf-to-root
// walk for queries, and the result register.
module rmq_seq #(
   parameter int LEAVES = rmq_pkg::LEAVES_DEFAULT,
   localparam int SPAN = 1 << $clog2(LEAVES),
   localparam int LEAF_W = $clog2(SPAN),
   localparam int ADDR_W = LEAF_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [rmq_pkg::INDEX_W-1:0] req_first_index,
   input  logic [rmq_pkg::INDEX_W-1:0] req_last_index,
   input  logic [rmq_pkg::VALUE_W-1:0] req_new_value,
   input  logic [rmq_pkg::INDEX_W-1:0] req_query_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmq_pkg::VALUE_W-1:0] rsp_min_value,
   output rmq_pkg::ram_ctl_type        ram_ctl,
   output logic [ADDR_W-1:0]           ram_wr_addr,
   output logic [rmq_pkg::VALUE_W-1:0] ram_wr_data,
   output logic [ADDR_W-1:0]           ram_rd_addr,
   input  logic [rmq_pkg::VALUE_W-1:0] ram_rd_data
);

   localparam int BOUND_W = ADDR_W + 1;

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_UPD_STEP = 7'b0000100,
      ST_UPD_CMP  = 7'b0001000,
      ST_QRY_READ = 7'b0010000,
      ST_QRY_CMP  = 7'b0100000,
      ST_QRY_DONE = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rmq_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [BOUND_W-1:0]          lo_ff, lo_in;
   logic [BOUND_W-1:0]          hi_ff, hi_in;
   logic [ADDR_W-1:0]           target_ff, target_in;
   logic [ADDR_W-1:0]           node_ff, node_in;
   logic [rmq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [rmq_pkg::VALUE_W-1:0] acc_ff, acc_in;

   logic                        first_over;
   logic                        last_over;
   logic                        query_over;
   logic [LEAF_W-1:0]           last_clip;
   logic                        range_empty;
   logic [BOUND_W-1:0]          lo_start;
   logic [BOUND_W-1:0]          hi_start;
   logic [BOUND_W-1:0]          hi_dec;
   logic [ADDR_W-1:0]           node_start;
   logic [rmq_pkg::VALUE_W-1:0] min_a;
   logic [rmq_pkg::VALUE_W-1:0] min_b;
   logic [rmq_pkg::VALUE_W-1:0] min_out;

   rmq_min_unit u_min (
      .a_value   (min_a),
      .b_value   (min_b),
      .min_value (min_out)
   );

   // Request decode. Leaf positions are offset by SPAN to give heap order.
   always_comb begin
      first_over  = 32'(req_first_index) >= 32'(LEAVES);
      last_over   = 32'(req_last_index) >= 32'(LEAVES);
      query_over  = 32'(req_query_index) >= 32'(LEAVES);
      last_clip   = last_over ? LEAF_W'(LEAVES - 1) : LEAF_W'(req_last_index);
      range_empty = first_over || (LEAF_W'(req_first_index) > last_clip);
      lo_start    = {2'b01, LEAF_W'(req_first_index)};
      hi_start    = {2'b01, last_clip} + BOUND_W'(1);
      node_start  = {1'b1, LEAF_W'(req_query_index)};
      hi_dec      = hi_ff - BOUND_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      target_in    = target_ff;
      node_in      = node_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      req_ready    = 1'b0;
      ram_ctl      = '0;
      ram_wr_addr  = target_ff;
      ram_wr_data  = min_out;
      ram_rd_addr  = node_ff;
      min_a        = ram_rd_data;
      min_b        = acc_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_wr_addr   = clr_ff;
            ram_wr_data   = rmq_pkg::SENTINEL;
            clr_in        = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == rmq_pkg::KIND_UPDATE) begin
                  value_in = req_new_value;
                  lo_in    = lo_start;
                  hi_in    = hi_start;
                  if (!range_empty) begin
                     state_in = ST_UPD_STEP;
                  end
               end else begin
                  acc_in   = rmq_pkg::SENTINEL;
                  node_in  = node_start;
                  state_in = query_over ? ST_QRY_DONE : ST_QRY_READ;
               end
            end
         end
         ST_UPD_STEP: begin
            // One covering node per visit; a level shift when neither edge is odd.
            if (lo_ff >= hi_ff) begin
               state_in = ST_IDLE;
            end else if (lo_ff[0]) begin
               target_in     = lo_ff[ADDR_W-1:0];
               lo_in         = lo_ff + BOUND_W'(1);
               ram_ctl.rd_en = 1'b1;
               ram_rd_addr   = target_in;
               state_in      = ST_UPD_CMP;
            end else if (hi_ff[0]) begin
               target_in     = hi_dec[ADDR_W-1:0];
               hi_in         = hi_dec;
               ram_ctl.rd_en = 1'b1;
               ram_rd_addr   = target_in;
               state_in      = ST_UPD_CMP;
            end else begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
            end
         end
         ST_UPD_CMP: begin
            min_a         = value_ff;
            min_b         = ram_rd_data;
            ram_ctl.wr_en = 1'b1;
            state_in      = ST_UPD_STEP;
         end
         ST_QRY_READ: begin
            ram_ctl.rd_en = 1'b1;
            state_in      = ST_QRY_CMP;
         end
         ST_QRY_CMP: begin
            acc_in  = min_out;
            node_in = node_ff >> 1;
            state_in = (node_ff == ADDR_W'(1)) ? ST_QRY_DONE : ST_QRY_READ;
         end
         ST_QRY_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      target_ff    <= target_in;
      node_ff      <= node_in;
      value_ff     <= value_in;
      acc_ff       <= acc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_value_ff;

endmodule

// ===== rtl/range_min_update_point_query_tree.sv =====
// Segment tree over LEAVES leaf positions (padded to a power of two, SPAN)
// that lowers whole ranges to at most a bound and answers point queries.
// The request channel (req_*) carries either a range update (req_kind = 0:
// first index, last index inclusive, new value) or a point query
// (req_kind = 1: query index). Updates produce no response; each query
// produces one response on the rsp_* channel with the smallest bound that
// covers the position, or the sentinel 1e18+7 if none does.
// After reset the block clears all 2*SPAN entries of its node store (2048 at
// the default size) with req_ready low, then accepts requests.
// One request is worked on at a time through a node memory with one write
// port, one read port with registered read data, and one shared compare unit.
// A query reads and then compares one node per tree level, from its leaf up
// to the root, and then hands the result to the output register.
// An update walks the range up level by level; each covering node, at most
// two per level, is read and then rewritten with the smaller value.
// Empty updates (also a first index out of range) finish in the accept cycle.
// The result sits in an output register; a new request is accepted while it
// waits. A query that finishes while the earlier result still waits holds
// until the receiver takes it.
module range_min_update_point_query_tree #(
   parameter int LEAVES = rmq_pkg::LEAVES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [rmq_pkg::INDEX_W-1:0] req_first_index,
   input  logic [rmq_pkg::INDEX_W-1:0] req_last_index,
   input  logic [rmq_pkg::VALUE_W-1:0] req_new_value,
   input  logic [rmq_pkg::INDEX_W-1:0] req_query_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmq_pkg::VALUE_W-1:0] rsp_min_value
);

   // Node addresses run from 1 to 2*SPAN-1 in heap order.
   localparam int SPAN = 1 << $clog2(LEAVES);
   localparam int ADDR_W = $clog2(SPAN) + 1;

   rmq_pkg::ram_ctl_type        ram_ctl;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [rmq_pkg::VALUE_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]           ram_rd_addr;
   logic [rmq_pkg::VALUE_W-1:0] ram_rd_data;

   rmq_seq #(
      .LEAVES (LEAVES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_new_value   (req_new_value),
      .req_query_index (req_query_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_min_value   (rsp_min_value),
      .ram_ctl         (ram_ctl),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   rmq_node_ram #(
      .ADDR_W (ADDR_W)
   ) u_node_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_kind,
   input logic [rmq_pkg::INDEX_W-1:0] req_query_index,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rmq_pkg::VALUE_W-1:0] rsp_min_value
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_value))
      else $error("stalled response changed");

   // An accepted query leaves idle for the walk or the result state, so the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == rmq_pkg::KIND_QUERY |=> !req_ready)
      else $error("ready right after a query");

   // The walk starts from the sentinel, so no answer can exceed it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_value <= rmq_pkg::SENTINEL)
      else $error("response above sentinel");

   // The clearing pass follows reset: no request taken, no response shown.
   assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   // A waiting request stays valid and keeps its query index until taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_query_index))
      else $error("stalled query index changed");

endmodule

bind range_min_update_point_query_tree rmq_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_kind        (req_kind),
   .req_query_index (req_query_index),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_min_value   (rsp_min_value)
);
